// File: rtl/scan_code_to_ascii_translator_top_assert.svh
// Assertion macros used by the translator's back module.
`ifndef SCAN_CODE_TO_ASCII_TRANSLATOR_TOP_ASSERT_SVH
`define SCAN_CODE_TO_ASCII_TRANSLATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCTA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/scta_pkg.sv
`timescale 1ns / 1ps

package scta_pkg;

    localparam int NUM_CONSOLES_DEFAULT = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_RAW     = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_CONSOLE = 2'd2;

    localparam logic [7:0] SCAN_PREFIX_E0    = 8'hE0;
    localparam logic [7:0] CTRL_MARK         = 8'h8F;
    localparam logic [7:0] FKEY_BASE         = 8'h3B;
    localparam logic [7:0] SCAN_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SCAN_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SCAN_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SCAN_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SCAN_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SCAN_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SCAN_CAPS_LOCK    = 8'h3A;

    typedef struct packed {
        logic [7:0] scan_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } out_item_t;

    // Work handed from the front to the back: the echo plus up to two more results.
    typedef struct packed {
        logic [7:0] raw;
        logic [1:0] n_extra;
        logic [1:0] kind1;
        logic [7:0] value1;
        logic [1:0] kind2;
        logic [7:0] value2;
    } plan_t;

    function automatic logic is_letter(input logic [7:0] k);
        return (k inside {[8'h10:8'h19], [8'h1E:8'h26], [8'h2C:8'h32]});
    endfunction

    function automatic logic [7:0] normal_rom(input logic [7:0] k);
        logic [7:0] ch;
        case (k)
            8'h01: ch = 8'h85;
            8'h02: ch = 8'h31;
            8'h03: ch = 8'h32;
            8'h04: ch = 8'h33;
            8'h05: ch = 8'h34;
            8'h06: ch = 8'h35;
            8'h07: ch = 8'h36;
            8'h08: ch = 8'h37;
            8'h09: ch = 8'h38;
            8'h0A: ch = 8'h39;
            8'h0B: ch = 8'h30;
            8'h0C: ch = 8'h2D;
            8'h0D: ch = 8'h3D;
            8'h0E: ch = 8'h08;
            8'h0F: ch = 8'h09;
            8'h10: ch = 8'h71;
            8'h11: ch = 8'h77;
            8'h12: ch = 8'h65;
            8'h13: ch = 8'h72;
            8'h14: ch = 8'h74;
            8'h15: ch = 8'h79;
            8'h16: ch = 8'h75;
            8'h17: ch = 8'h69;
            8'h18: ch = 8'h6F;
            8'h19: ch = 8'h70;
            8'h1A: ch = 8'h5B;
            8'h1B: ch = 8'h5D;
            8'h1C: ch = 8'h0A;
            8'h1E: ch = 8'h61;
            8'h1F: ch = 8'h73;
            8'h20: ch = 8'h64;
            8'h21: ch = 8'h66;
            8'h22: ch = 8'h67;
            8'h23: ch = 8'h68;
            8'h24: ch = 8'h6A;
            8'h25: ch = 8'h6B;
            8'h26: ch = 8'h6C;
            8'h27: ch = 8'h3B;
            8'h28: ch = 8'h27;
            8'h2B: ch = 8'h23;
            8'h2C: ch = 8'h7A;
            8'h2D: ch = 8'h78;
            8'h2E: ch = 8'h63;
            8'h2F: ch = 8'h76;
            8'h30: ch = 8'h62;
            8'h31: ch = 8'h6E;
            8'h32: ch = 8'h6D;
            8'h33: ch = 8'h2C;
            8'h34: ch = 8'h2E;
            8'h35: ch = 8'h2F;
            8'h39: ch = 8'h20;
            8'h47: ch = 8'h37;
            8'h48: ch = 8'h38;
            8'h49: ch = 8'h39;
            8'h4B: ch = 8'h34;
            8'h4C: ch = 8'h35;
            8'h4D: ch = 8'h36;
            8'h4F: ch = 8'h31;
            8'h50: ch = 8'h32;
            8'h51: ch = 8'h33;
            8'h56: ch = 8'h5C;
            8'h57: ch = 8'h34;
            8'h58: ch = 8'h35;
            8'h59: ch = 8'h36;
            8'h5A: ch = 8'h37;
            8'h5B: ch = 8'h38;
            8'h5C: ch = 8'h39;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] shifted_rom(input logic [7:0] k);
        logic [7:0] ch;
        case (k)
            8'h02: ch = 8'h21;
            8'h03: ch = 8'h22;
            8'h04: ch = 8'hA3;
            8'h05: ch = 8'h24;
            8'h06: ch = 8'h25;
            8'h07: ch = 8'h5E;
            8'h08: ch = 8'h26;
            8'h09: ch = 8'h2A;
            8'h0A: ch = 8'h28;
            8'h0B: ch = 8'h29;
            8'h0C: ch = 8'h5F;
            8'h0D: ch = 8'h2B;
            8'h0E: ch = 8'h08;
            8'h10: ch = 8'h51;
            8'h11: ch = 8'h57;
            8'h12: ch = 8'h45;
            8'h13: ch = 8'h52;
            8'h14: ch = 8'h54;
            8'h15: ch = 8'h59;
            8'h16: ch = 8'h55;
            8'h17: ch = 8'h49;
            8'h18: ch = 8'h4F;
            8'h19: ch = 8'h50;
            8'h1A: ch = 8'h7B;
            8'h1B: ch = 8'h7D;
            8'h1C: ch = 8'h0A;
            8'h1E: ch = 8'h41;
            8'h1F: ch = 8'h53;
            8'h20: ch = 8'h44;
            8'h21: ch = 8'h46;
            8'h22: ch = 8'h47;
            8'h23: ch = 8'h48;
            8'h24: ch = 8'h4A;
            8'h25: ch = 8'h4B;
            8'h26: ch = 8'h4C;
            8'h27: ch = 8'h3A;
            8'h28: ch = 8'h40;
            8'h2B: ch = 8'h7E;
            8'h2C: ch = 8'h5A;
            8'h2D: ch = 8'h58;
            8'h2E: ch = 8'h43;
            8'h2F: ch = 8'h56;
            8'h30: ch = 8'h42;
            8'h31: ch = 8'h4E;
            8'h32: ch = 8'h4D;
            8'h33: ch = 8'h3C;
            8'h34: ch = 8'h3E;
            8'h35: ch = 8'h3F;
            8'h39: ch = 8'h20;
            8'h4F: ch = 8'h31;
            8'h50: ch = 8'h32;
            8'h51: ch = 8'h33;
            8'h54: ch = 8'h34;
            8'h55: ch = 8'h35;
            8'h56: ch = 8'h7C;
            8'h57: ch = 8'h37;
            8'h58: ch = 8'h38;
            8'h59: ch = 8'h39;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] extended_rom(input logic [7:0] k);
        logic [7:0] ch;
        case (k)
            8'h1C: ch = 8'h0A;
            8'h48: ch = 8'h81;
            8'h4B: ch = 8'h83;
            8'h4D: ch = 8'h84;
            8'h50: ch = 8'h82;
            8'h53: ch = 8'h7F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/scta_stream_if.sv
`timescale 1ns / 1ps

// Valid/ready channel; a transfer happens when both are high at a rising edge.
interface scta_stream_if #(parameter type payload_t = logic) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// File: rtl/scta_front.sv
`timescale 1ns / 1ps

module scta_front
    import scta_pkg::*;
#(
    parameter int NUM_CONSOLES = NUM_CONSOLES_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic [7:0] scan_byte,
    output plan_t     plan
);

    localparam logic [8:0] FKEY_LAST = 9'(FKEY_BASE) + 9'(NUM_CONSOLES - 1);

    logic shift_held_reg, shift_held_next;
    logic ctrl_held_reg, ctrl_held_next;
    logic caps_on_reg, caps_on_next;
    logic extended_pending_reg, extended_pending_next;

    logic [7:0] ext_ch;
    logic [7:0] key_ch;
    logic       letter;
    logic       fkey;

    always_comb
    begin
        ext_ch = extended_rom(scan_byte);
        letter = is_letter(scan_byte);
        fkey   = {1'b0, scan_byte} inside {[9'(FKEY_BASE) : FKEY_LAST]};
        if (shift_held_reg && caps_on_reg)
        begin
            key_ch = letter ? normal_rom(scan_byte) : shifted_rom(scan_byte);
        end
        else if (shift_held_reg || (caps_on_reg && letter))
        begin
            key_ch = shifted_rom(scan_byte);
        end
        else
        begin
            key_ch = normal_rom(scan_byte);
        end
    end

    always_comb
    begin
        shift_held_next       = shift_held_reg;
        ctrl_held_next        = ctrl_held_reg;
        caps_on_next          = caps_on_reg;
        extended_pending_next = extended_pending_reg;

        plan.raw     = scan_byte;
        plan.n_extra = 2'd0;
        plan.kind1   = KIND_CHAR;
        plan.value1  = key_ch;
        plan.kind2   = KIND_CHAR;
        plan.value2  = key_ch;

        if (extended_pending_reg)
        begin
            extended_pending_next = 1'b0;
            plan.value1 = ext_ch;
            plan.n_extra = (ext_ch != 8'h00) ? 2'd1 : 2'd0;
        end
        else
        begin
            case (scan_byte)
                SCAN_CTRL_MAKE: ctrl_held_next = 1'b1;
                SCAN_LSHIFT_MAKE, SCAN_RSHIFT_MAKE: shift_held_next = 1'b1;
                SCAN_CAPS_LOCK: caps_on_next = !caps_on_reg;
                SCAN_CTRL_BREAK: ctrl_held_next = 1'b0;
                SCAN_LSHIFT_BREAK, SCAN_RSHIFT_BREAK: shift_held_next = 1'b0;
                SCAN_PREFIX_E0: extended_pending_next = 1'b1;
                default:
                begin
                    if (!scan_byte[7])
                    begin
                        if (shift_held_reg && fkey)
                        begin
                            plan.n_extra = 2'd1;
                            plan.kind1   = KIND_CONSOLE;
                            plan.value1  = 8'(scan_byte - FKEY_BASE);
                        end
                        else if (ctrl_held_reg && !(shift_held_reg && caps_on_reg))
                        begin
                            // Ctrl marker goes out ahead of the character.
                            plan.n_extra = 2'd2;
                            plan.value1  = CTRL_MARK;
                        end
                        else
                        begin
                            plan.n_extra = 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_held_reg       <= 1'b0;
            ctrl_held_reg        <= 1'b0;
            caps_on_reg          <= 1'b0;
            extended_pending_reg <= 1'b0;
        end
        else if (take)
        begin
            shift_held_reg       <= shift_held_next;
            ctrl_held_reg        <= ctrl_held_next;
            caps_on_reg          <= caps_on_next;
            extended_pending_reg <= extended_pending_next;
        end
    end

endmodule

// File: rtl/scta_queue.sv
`timescale 1ns / 1ps

module scta_queue
    import scta_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  plan_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  nonempty,
    output plan_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    plan_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign nonempty = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/scta_back.sv
`timescale 1ns / 1ps

`include "scan_code_to_ascii_translator_top_assert.svh"

module scta_back
    import scta_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_nonempty,
    input  plan_t q_data,
    output logic  pop,
    scta_stream_if.source result_out
);

    logic       busy_reg, busy_next;
    logic [1:0] step_reg, step_next;
    plan_t      entry_reg, entry_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    logic       load;
    out_item_t  cur;

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

    always_comb
    begin
        case (step_reg)
            2'd0: cur = '{kind: KIND_RAW, value: entry_reg.raw,
                          last: (entry_reg.n_extra == 2'd0)};
            2'd1: cur = '{kind: entry_reg.kind1, value: entry_reg.value1,
                          last: (entry_reg.n_extra == 2'd1)};
            default: cur = '{kind: entry_reg.kind2, value: entry_reg.value2, last: 1'b1};
        endcase
    end

    always_comb
    begin
        load           = !out_valid_reg || result_out.ready;
        pop            = 1'b0;
        busy_next      = busy_reg;
        step_next      = step_reg;
        entry_next     = entry_reg;
        out_valid_next = out_valid_reg && !result_out.ready;
        out_data_next  = out_data_reg;

        if (busy_reg)
        begin
            if (load)
            begin
                out_valid_next = 1'b1;
                out_data_next  = cur;
                if (cur.last)
                begin
                    pop        = q_nonempty;
                    busy_next  = q_nonempty;
                    entry_next = q_data;
                    step_next  = 2'd0;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
        end
        else if (q_nonempty)
        begin
            pop        = 1'b1;
            busy_next  = 1'b1;
            entry_next = q_data;
            step_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        out_data_reg <= out_data_next;
    end

    `SCTA_ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, q_nonempty,
        "queue popped while empty")
    `SCTA_ASSERT_SAME(a_step_bound, clk, rst_n, busy_reg && (step_reg != 2'd0),
        step_reg <= entry_reg.n_extra, "result step beyond the planned count")
    `SCTA_ASSERT_SAME(a_item_open, clk, rst_n, out_valid_reg && !out_data_reg.last,
        busy_reg, "item left unfinished after a non-final result")
    `SCTA_ASSERT_NEXT(a_last_advances, clk, rst_n, busy_reg && load && !cur.last,
        busy_reg && (step_reg == $past(step_reg) + 2'd1), "step did not advance")

endmodule

// File: rtl/scan_code_to_ascii_translator_top.sv
`timescale 1ns / 1ps

// Channel      Direction  Payload                      Transfer when
// scan_in      sink       scan_byte[7:0]               valid && ready
// result_out   source     kind[1:0], value[7:0], last  valid && ready
//
// Each scan byte yields one to three results, one per cycle from the single result
// register while result_out.ready is high, holding the channel until the last one.
// With the back idle, the first result passes the queue, entry and result registers.
// The front takes a byte whenever the two-entry queue has room, also while a
// result is stalled; only a full queue drops scan_in.ready.
// Reset clears the flags, the queue and the output valid; input is ready at once.
module scan_code_to_ascii_translator_top
    import scta_pkg::*;
#(
    parameter int NUM_CONSOLES = NUM_CONSOLES_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    scta_stream_if.sink   scan_in,
    scta_stream_if.source result_out
);

    // Front-to-back plan queue.
    logic  q_full;
    logic  q_nonempty;
    logic  q_pop;
    logic  take;
    plan_t plan;
    plan_t q_data;

    // A byte is taken whenever the queue can hold its plan.
    assign scan_in.ready = !q_full;
    assign take          = scan_in.valid && !q_full;

    // The front decodes the byte against the current modifiers and builds
    // the list of results it causes.
    scta_front #(
        .NUM_CONSOLES (NUM_CONSOLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .scan_byte (scan_in.data.scan_byte),
        .plan      (plan)
    );

    scta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (plan),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_data  (q_data)
    );

    // The back walks each plan, one result per transfer on the output.
    scta_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_data     (q_data),
        .pop        (q_pop),
        .result_out (result_out)
    );

endmodule
